>>> rtl/core/dqpe_pkg.sv
// Package for the DNS query extractor: payload structs, queue status,
// frame offsets and protocol codes. No dependencies.
`timescale 1ns / 1ps

package dqpe_pkg;

   localparam int NAME_MAX_LEN = 256;

   localparam logic [15:0] WATCHED_PORT_RESET = 16'd53;

   // Frame byte offsets, counted from the first Ethernet byte.
   localparam logic [9:0] POS_ETH_HI     = 10'd12;
   localparam logic [9:0] POS_ETH_LO     = 10'd13;
   localparam logic [9:0] POS_PROTO      = 10'd23;
   localparam logic [9:0] POS_SRC_FIRST  = 10'd26;
   localparam logic [9:0] POS_SRC_LAST   = 10'd29;
   localparam logic [9:0] POS_DST_FIRST  = 10'd30;
   localparam logic [9:0] POS_DST_LAST   = 10'd33;
   localparam logic [9:0] POS_SPORT_HI   = 10'd34;
   localparam logic [9:0] POS_SPORT_LO   = 10'd35;
   localparam logic [9:0] POS_DPORT_HI   = 10'd36;
   localparam logic [9:0] POS_DPORT_LO   = 10'd37;
   localparam logic [9:0] POS_ID_HI      = 10'd42;
   localparam logic [9:0] POS_ID_LO      = 10'd43;
   localparam logic [9:0] POS_FLAGS      = 10'd44;
   localparam logic [9:0] NAME_START     = 10'd54;
   localparam logic [9:0] TAIL_LAST_OFFS = 10'd57;
   localparam logic [9:0] POS_TOP        = 10'd1023;

   localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
   localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [7:0]  FLAGS_MASK   = 8'hF8;
   localparam logic [15:0] QTYPE_A      = 16'd1;
   localparam logic [15:0] QTYPE_AAAA   = 16'd28;
   localparam logic [15:0] QCLASS_IN    = 16'd1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] query_id;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [8:0]  name_length;
      logic [4:0]  chunk_index;
      logic [63:0] name_chunk;
      logic        last_chunk;
   } rsp_type;

   // One qualified query, waiting for its name to be read out.
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] query_id;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [8:0]  name_length;
      logic        bank;
   } event_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LOAD
   } back_state_type;

   // Address bits for the 8-byte words of one name bank.
   function automatic int chunk_addr_width(input int name_max);
      int chunks;
      chunks = (name_max + 7) / 8;
      return (chunks > 1) ? $clog2(chunks) : 1;
   endfunction

endpackage

>>> rtl/core/dqpe_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module dqpe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dqpe_front.sv
// Front end of the DNS query extractor: parses frame bytes, holds the port
// register, packs name bytes into 8-byte RAM words and pushes events.
// Depends on dqpe_pkg.
`timescale 1ns / 1ps

module dqpe_front #(
   parameter int NAME_MAX_LEN = dqpe_pkg::NAME_MAX_LEN,
   parameter int AW = dqpe_pkg::chunk_addr_width(NAME_MAX_LEN) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  dqpe_pkg::req_type    item,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [63:0]          wr_data,
   output logic                 push,
   output dqpe_pkg::event_type  push_event
);

   localparam int IW = $clog2(NAME_MAX_LEN);
   localparam int CW = AW - 1;

   logic [15:0] port_ff, port_in;
   logic [9:0]  pos_ff, pos_in;
   logic        rej_ff, rej_in;
   logic        done_ff, done_in;
   logic        complete_ff, complete_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] tail_ff, tail_in;
   logic [8:0]  len_ff, len_in;
   logic [63:0] acc_ff, acc_in;
   logic        bank_ff, bank_in;

   logic [IW-1:0] name_idx;
   logic [2:0]    lane;
   logic [63:0]   word_v;
   logic [15:0]   dport_v;
   logic [31:0]   tail_v;
   logic          event_hit;
   logic          type_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff     <= dqpe_pkg::WATCHED_PORT_RESET;
         pos_ff      <= '0;
         rej_ff      <= 1'b0;
         done_ff     <= 1'b0;
         complete_ff <= 1'b0;
         src_ff      <= '0;
         dst_ff      <= '0;
         sport_ff    <= '0;
         dport_ff    <= '0;
         id_ff       <= '0;
         tail_ff     <= '0;
         len_ff      <= '0;
         bank_ff     <= 1'b0;
      end else begin
         port_ff     <= port_in;
         pos_ff      <= pos_in;
         rej_ff      <= rej_in;
         done_ff     <= done_in;
         complete_ff <= complete_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         sport_ff    <= sport_in;
         dport_ff    <= dport_in;
         id_ff       <= id_in;
         tail_ff     <= tail_in;
         len_ff      <= len_in;
         bank_ff     <= bank_in;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      port_in     = csr_wr_en ? csr_wr_data : port_ff;
      pos_in      = pos_ff;
      rej_in      = rej_ff;
      done_in     = done_ff;
      complete_in = complete_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      sport_in    = sport_ff;
      dport_in    = dport_ff;
      id_in       = id_ff;
      tail_in     = tail_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      wr_en       = 1'b0;
      push        = 1'b0;

      name_idx = IW'(pos_ff - dqpe_pkg::NAME_START);
      lane     = name_idx[2:0];
      word_v   = (lane == 3'd0) ? 64'd0 : acc_ff;
      word_v[(7 - int'(lane)) * 8 +: 8] = item.data_byte;
      dport_v   = {dport_ff[7:0], item.data_byte};
      tail_v    = {tail_ff[23:0], item.data_byte};
      event_hit = (pos_ff == dqpe_pkg::TAIL_LAST_OFFS + 10'(len_ff));
      type_ok   = ((tail_v[31:16] == dqpe_pkg::QTYPE_A) ||
                   (tail_v[31:16] == dqpe_pkg::QTYPE_AAAA)) &&
                  (tail_v[15:0] == dqpe_pkg::QCLASS_IN);

      if (accept) begin
         if (!rej_ff && !done_ff) begin
            if (pos_ff == dqpe_pkg::POS_ETH_HI && item.data_byte != dqpe_pkg::ETHERTYPE_HI) begin
               rej_in = 1'b1;
            end
            if (pos_ff == dqpe_pkg::POS_ETH_LO && item.data_byte != dqpe_pkg::ETHERTYPE_LO) begin
               rej_in = 1'b1;
            end
            if (pos_ff == dqpe_pkg::POS_PROTO && item.data_byte != dqpe_pkg::PROTO_UDP) begin
               rej_in = 1'b1;
            end
            if (pos_ff inside {[dqpe_pkg::POS_SRC_FIRST:dqpe_pkg::POS_SRC_LAST]}) begin
               src_in = {src_ff[23:0], item.data_byte};
            end
            if (pos_ff inside {[dqpe_pkg::POS_DST_FIRST:dqpe_pkg::POS_DST_LAST]}) begin
               dst_in = {dst_ff[23:0], item.data_byte};
            end
            if (pos_ff inside {dqpe_pkg::POS_SPORT_HI, dqpe_pkg::POS_SPORT_LO}) begin
               sport_in = {sport_ff[7:0], item.data_byte};
            end
            if (pos_ff inside {dqpe_pkg::POS_DPORT_HI, dqpe_pkg::POS_DPORT_LO}) begin
               dport_in = dport_v;
               if (pos_ff == dqpe_pkg::POS_DPORT_LO && dport_v != port_ff) begin
                  rej_in = 1'b1;
               end
            end
            if (pos_ff inside {dqpe_pkg::POS_ID_HI, dqpe_pkg::POS_ID_LO}) begin
               id_in = {id_ff[7:0], item.data_byte};
            end
            if (pos_ff == dqpe_pkg::POS_FLAGS &&
                (item.data_byte & dqpe_pkg::FLAGS_MASK) != 8'd0) begin
               rej_in = 1'b1;
            end
            if (pos_ff >= dqpe_pkg::NAME_START) begin
               if (!complete_ff) begin
                  // Name byte: the word goes to RAM when full or at the root label.
                  acc_in = word_v;
                  wr_en  = (lane == 3'd7) || (item.data_byte == 8'd0);
                  if (item.data_byte == 8'd0) begin
                     complete_in = 1'b1;
                     len_in      = 9'(name_idx) + 9'd1;
                  end else if (name_idx == IW'(NAME_MAX_LEN - 1)) begin
                     rej_in = 1'b1;
                  end
               end else begin
                  tail_in = tail_v;
                  if (event_hit) begin
                     done_in = 1'b1;
                     push    = type_ok;
                  end
               end
            end
         end
         if (item.last_byte) begin
            pos_in      = '0;
            rej_in      = 1'b0;
            done_in     = 1'b0;
            complete_in = 1'b0;
            src_in      = '0;
            dst_in      = '0;
            sport_in    = '0;
            dport_in    = '0;
            id_in       = '0;
            tail_in     = '0;
            len_in      = '0;
         end else if (pos_ff != dqpe_pkg::POS_TOP) begin
            pos_in = pos_ff + 10'd1;
         end
      end
   end

   // Each queued event owns a bank; the next name goes to the other one.
   assign bank_in = bank_ff ^ push;
   assign wr_addr = {bank_ff, CW'(name_idx >> 3)};
   assign wr_data = word_v;

   always_comb begin
      push_event.src_addr    = src_ff;
      push_event.dst_addr    = dst_ff;
      push_event.src_port    = sport_ff;
      push_event.dst_port    = dport_ff;
      push_event.query_id    = id_ff;
      push_event.query_type  = tail_v[31:16];
      push_event.query_class = tail_v[15:0];
      push_event.name_length = len_ff;
      push_event.bank        = bank_ff;
   end

   a_push_needs_name : assert property (@(posedge clock) disable iff (reset)
      push |-> (complete_ff && !rej_ff && !done_ff && len_ff != 9'd0))
      else $error("event pushed without a complete name");

endmodule

>>> rtl/core/dqpe_queue.sv
// Two-entry event queue between the parser and the result sequencer.
// Depends on dqpe_pkg.
`timescale 1ns / 1ps

module dqpe_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dqpe_pkg::event_type        push_event,
   input  logic                       pop,
   output dqpe_pkg::event_type        head,
   output dqpe_pkg::queue_status_type status
);

   localparam int PW = $clog2(dqpe_pkg::QUEUE_DEPTH);

   dqpe_pkg::event_type entry_ff [dqpe_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PW+1)'(dqpe_pkg::QUEUE_DEPTH));

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("event pushed into a full queue");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("event popped from an empty queue");

endmodule

>>> rtl/core/dqpe_back.sv
// Result sequencer: reads the name of the head event one 8-byte word at a
// time and drives the result register. Depends on dqpe_pkg.
`timescale 1ns / 1ps

module dqpe_back #(
   parameter int NAME_MAX_LEN = dqpe_pkg::NAME_MAX_LEN,
   parameter int AW = dqpe_pkg::chunk_addr_width(NAME_MAX_LEN) + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dqpe_pkg::event_type        head,
   input  dqpe_pkg::queue_status_type status,
   output logic                       pop,
   output logic [AW-1:0]              rd_addr,
   input  logic [63:0]                rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dqpe_pkg::rsp_type          rsp_item
);

   localparam int CW = AW - 1;

   dqpe_pkg::back_state_type state_ff, state_in;
   logic [4:0]        chunk_ff, chunk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dqpe_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic              slot_free;
   logic              is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqpe_pkg::BK_IDLE;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (chunk_ff == 5'((head.name_length - 9'd1) >> 3));
   assign rd_addr   = {head.bank, CW'(chunk_ff)};

   always_comb begin
      state_in     = state_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      pop          = 1'b0;

      case (state_ff)
         dqpe_pkg::BK_IDLE: begin
            // The address already points at word zero of the head event.
            if (!status.empty) begin
               state_in = dqpe_pkg::BK_LOAD;
            end
         end
         dqpe_pkg::BK_FETCH: begin
            state_in = dqpe_pkg::BK_LOAD;
         end
         dqpe_pkg::BK_LOAD: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.src_addr    = head.src_addr;
               rsp_item_in.dst_addr    = head.dst_addr;
               rsp_item_in.src_port    = head.src_port;
               rsp_item_in.dst_port    = head.dst_port;
               rsp_item_in.query_id    = head.query_id;
               rsp_item_in.query_type  = head.query_type;
               rsp_item_in.query_class = head.query_class;
               rsp_item_in.name_length = head.name_length;
               rsp_item_in.chunk_index = chunk_ff;
               rsp_item_in.name_chunk  = rd_data;
               rsp_item_in.last_chunk  = is_last;
               if (is_last) begin
                  pop      = 1'b1;
                  chunk_in = '0;
                  state_in = dqpe_pkg::BK_IDLE;
               end else begin
                  chunk_in = chunk_ff + 5'd1;
                  state_in = dqpe_pkg::BK_FETCH;
               end
            end
         end
         default: begin
            state_in = dqpe_pkg::BK_IDLE;
            chunk_in = '0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_chunk_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqpe_pkg::BK_LOAD) |->
         (chunk_ff <= 5'((head.name_length - 9'd1) >> 3)))
      else $error("name word index past the captured length");

   a_busy_has_event : assert property (@(posedge clock) disable iff (reset)
      (state_ff != dqpe_pkg::BK_IDLE) |-> !status.empty)
      else $error("sequencer busy with no queued event");

endmodule

>>> rtl/core/dns_query_packet_extractor.sv
// Top level of the DNS query extractor: parser, event queue, name RAM and
// result sequencer. Depends on dqpe_pkg, dqpe_front, dqpe_queue, dqpe_ram, dqpe_back.
`timescale 1ns / 1ps

// The block takes an Ethernet frame one byte per item, with last_byte set on
// the final byte, and picks out IPv4/UDP DNS standard queries whose UDP
// destination port equals the port register (csr_wr_data, reset 53). The IPv4
// header is always taken as 20 bytes. For a query of type A or AAAA and class
// IN it gives one result item per 8-byte slice of the question name, each
// carrying addresses, ports, id, type, class and the name length; last_chunk
// marks the final one. Frames that end early, fail a check or carry a name
// longer than NAME_MAX_LEN give nothing. Input bytes are taken one per cycle
// while req_stall is low. A qualified query goes into a two-entry queue and
// its name into one of two banks of the name RAM; while two queries wait,
// req_stall is high. The result sequencer reads one name word per RAM read,
// registering a result item in LOAD when the output is free and passing
// through FETCH before each further word. The name RAM is never cleared:
// every word read was written by the frame that produced the query. The port
// register may be written at any time; its value at the last destination-port
// byte decides.

module dns_query_packet_extractor #(
   parameter int NAME_MAX_LEN = dqpe_pkg::NAME_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqpe_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqpe_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   // One bank bit above the word address of a name.
   localparam int AW = dqpe_pkg::chunk_addr_width(NAME_MAX_LEN) + 1;
   localparam int RAM_DEPTH = 1 << AW;

   logic                       accept;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [63:0]                wr_data;
   logic [AW-1:0]              rd_addr;
   logic [63:0]                rd_data;
   logic                       push;
   logic                       pop;
   dqpe_pkg::event_type        push_event;
   dqpe_pkg::event_type        head;
   dqpe_pkg::queue_status_type status;

   // With both queue entries taken, both name banks are in use.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   dqpe_front #(
      .NAME_MAX_LEN (NAME_MAX_LEN),
      .AW           (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .push        (push),
      .push_event  (push_event)
   );

   dqpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   dqpe_ram #(
      .WIDTH (64),
      .DEPTH (RAM_DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dqpe_back #(
      .NAME_MAX_LEN (NAME_MAX_LEN),
      .AW           (AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // The parser must never write the bank that the sequencer is reading.
   a_bank_apart : assert property (@(posedge clock) disable iff (reset)
      (wr_en && !status.empty) |-> (wr_addr[AW-1] != head.bank))
      else $error("name write into a bank still being read");

endmodule

>>> tb/sv/dns_query_packet_extractor_test.sv
`timescale 1ns / 1ps

// Self-checking testbench for dns_query_packet_extractor. It sends whole frames one
// byte at a time and checks every name slice against a local predictor.
// Depends on dqpe_pkg and the block's RTL.

module dns_query_packet_extractor_test;
   import dqpe_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_GAP        = 18;
   // The block holds at most two queries and its parser takes each frame byte as it
   // is accepted. This pause covers a frame that is still in flight but gives no result.
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 115;
   localparam int PHASE_RESULTS  = 8;

   // Table markers: ANY means the row is checked only against the predictor.
   // NO_CUT means the frame is sent whole.
   localparam int ANY    = -1;
   localparam int NO_CUT = -1;

   localparam logic [15:0] ETH_IP4  = {ETHERTYPE_HI, ETHERTYPE_LO};
   localparam logic [15:0] DNS_PORT = WATCHED_PORT_RESET;

   // How the bytes of a frame that no check inspects are filled. A noise frame is
   // random from its first byte to its last.
   typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_NOISE} fill_kind_e;

   // One frame of stimulus. For a noise frame, cut gives the length.
   typedef struct {
      fill_kind_e  fill;
      logic [15:0] eth_type;
      logic [7:0]  proto;
      logic [15:0] dport;
      logic [7:0]  flags;
      int          name_len;   // name bytes before the zero byte
      logic [15:0] qtype;
      logic [15:0] qclass;
      int          trail;      // bytes after the class
      int          cut;        // frame truncated to this many bytes
      int          results;    // expected result count, or ANY
   } frame_spec_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_item;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   dns_query_packet_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state. This is a private copy of the parser's per-frame state
   // and of the port register.
   // ------------------------------------------------------------------------
   logic [15:0] port_setting;
   logic [9:0]  frame_pos;
   logic        frame_dropped;
   logic        query_emitted;
   logic        name_closed;
   logic [31:0] src_addr_acc;
   logic [31:0] dst_addr_acc;
   logic [31:0] type_class_acc;
   logic [15:0] src_port_acc;
   logic [15:0] dst_port_acc;
   logic [15:0] query_id_acc;
   logic [8:0]  name_len_acc;
   logic [7:0]  name_bytes [NAME_MAX_LEN];

   rsp_type     expected_slices [$];
   logic [7:0]  frame_bytes [$];
   int          error_count = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   function automatic void clear_frame_state();
      frame_pos      = '0;
      frame_dropped  = 1'b0;
      query_emitted  = 1'b0;
      name_closed    = 1'b0;
      src_addr_acc   = '0;
      dst_addr_acc   = '0;
      type_class_acc = '0;
      src_port_acc   = '0;
      dst_port_acc   = '0;
      query_id_acc   = '0;
      name_len_acc   = '0;
   endfunction

   // The last class byte of a qualifying query has arrived. Queue one result per
   // 8-byte slice of the captured name.
   function automatic int emit_query();
      logic [15:0] qtype;
      logic [15:0] qclass;
      int          len;
      int          slices;
      int          k;
      int          b;
      int          idx;
      rsp_type     slice;
      qtype  = type_class_acc[31:16];
      qclass = type_class_acc[15:0];
      if (!((qtype == QTYPE_A || qtype == QTYPE_AAAA) && qclass == QCLASS_IN))
         return 0;
      len    = name_len_acc;
      slices = (len + 7) / 8;
      for (k = 0; k < slices; k++) begin
         slice             = '0;
         slice.src_addr    = src_addr_acc;
         slice.dst_addr    = dst_addr_acc;
         slice.src_port    = src_port_acc;
         slice.dst_port    = dst_port_acc;
         slice.query_id    = query_id_acc;
         slice.query_type  = qtype;
         slice.query_class = qclass;
         slice.name_length = name_len_acc;
         slice.chunk_index = k[4:0];
         for (b = 0; b < 8; b++) begin
            idx = k * 8 + b;
            if (idx < len)
               slice.name_chunk[63 - 8 * b -: 8] = name_bytes[idx];
         end
         slice.last_chunk = (k + 1 == slices);
         expected_slices.push_back(slice);
      end
      return slices;
   endfunction

   // This handles one byte of a frame that is still alive. It returns the number
   // of results the byte causes.
   function automatic int parse_byte(input logic [7:0] b);
      int pos;
      int i;
      pos = frame_pos;
      if (pos == POS_ETH_HI && b != ETHERTYPE_HI)
         frame_dropped = 1'b1;
      else if (pos == POS_ETH_LO && b != ETHERTYPE_LO)
         frame_dropped = 1'b1;
      else if (pos == POS_PROTO && b != PROTO_UDP)
         frame_dropped = 1'b1;
      else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
         src_addr_acc = {src_addr_acc[23:0], b};
      else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
         dst_addr_acc = {dst_addr_acc[23:0], b};
      else if (pos == POS_SPORT_HI || pos == POS_SPORT_LO)
         src_port_acc = {src_port_acc[7:0], b};
      else if (pos == POS_DPORT_HI || pos == POS_DPORT_LO) begin
         dst_port_acc = {dst_port_acc[7:0], b};
         if (pos == POS_DPORT_LO && dst_port_acc != port_setting)
            frame_dropped = 1'b1;
      end else if (pos == POS_ID_HI || pos == POS_ID_LO)
         query_id_acc = {query_id_acc[7:0], b};
      else if (pos == POS_FLAGS && (b & FLAGS_MASK) != 8'h00)
         frame_dropped = 1'b1;
      else if (pos >= NAME_START) begin
         if (!name_closed) begin
            i = pos - NAME_START;
            name_bytes[i] = b;
            if (b == 8'h00) begin
               name_closed  = 1'b1;
               name_len_acc = i + 1;
            end else if (i + 1 >= NAME_MAX_LEN) begin
               frame_dropped = 1'b1;
            end
         end else begin
            type_class_acc = {type_class_acc[23:0], b};
            if (pos == TAIL_LAST_OFFS + name_len_acc) begin
               query_emitted = 1'b1;
               return emit_query();
            end
         end
      end
      return 0;
   endfunction

   // This advances the predictor by one accepted byte. parsed reports whether the
   // parser still cared about the byte.
   function automatic int predict_byte(input logic [7:0] b, input logic last,
                                       output bit parsed);
      int n;
      n      = 0;
      parsed = !frame_dropped && !query_emitted;
      if (parsed)
         n = parse_byte(b);
      if (last)
         clear_frame_state();
      else if (frame_pos < POS_TOP)
         frame_pos++;
      return n;
   endfunction

   // ------------------------------------------------------------------------
   // Frame construction.
   // ------------------------------------------------------------------------
   function automatic logic [7:0] fill_byte(input fill_kind_e fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Name bytes must never be zero before the terminator.
   function automatic logic [7:0] name_byte(input fill_kind_e fill);
      case (fill)
         FILL_ZERO: return 8'h01;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void build_frame(input frame_spec_t s);
      int p;
      frame_bytes.delete();
      if (s.fill == FILL_NOISE) begin
         for (p = 0; p < s.cut; p++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      for (p = 0; p < NAME_START; p++)
         frame_bytes.push_back(fill_byte(s.fill));
      frame_bytes[POS_ETH_HI]   = s.eth_type[15:8];
      frame_bytes[POS_ETH_LO]   = s.eth_type[7:0];
      frame_bytes[POS_PROTO]    = s.proto;
      frame_bytes[POS_DPORT_HI] = s.dport[15:8];
      frame_bytes[POS_DPORT_LO] = s.dport[7:0];
      frame_bytes[POS_FLAGS]    = s.flags;
      for (p = 0; p < s.name_len; p++)
         frame_bytes.push_back(name_byte(s.fill));
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(s.qtype[15:8]);
      frame_bytes.push_back(s.qtype[7:0]);
      frame_bytes.push_back(s.qclass[15:8]);
      frame_bytes.push_back(s.qclass[7:0]);
      for (p = 0; p < s.trail; p++)
         frame_bytes.push_back(fill_byte(s.fill));
      if (s.cut != NO_CUT)
         while (frame_bytes.size() > s.cut)
            void'(frame_bytes.pop_back());
   endfunction

   function automatic bit chance(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   // Random frames are mostly well-formed queries for the current port, so that
   // they get past every check and reach the name and the tail. The rest are
   // broken in one or more fields, truncated or plain noise.
   function automatic frame_spec_t random_spec();
      frame_spec_t s;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         s.fill = FILL_RAND;
      else if (pick < 89)
         s.fill = FILL_ZERO;
      else if (pick < 93)
         s.fill = FILL_ONES;
      else
         s.fill = FILL_NOISE;
      s.eth_type = chance(95) ? ETH_IP4 : 16'($urandom_range(0, 65535));
      s.proto    = chance(95) ? PROTO_UDP : 8'($urandom_range(0, 255));
      s.dport    = chance(90) ? port_setting : 16'($urandom_range(0, 65535));
      s.flags    = chance(92) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 88)
         s.name_len = $urandom_range(0, 24);
      else if (pick < 97)
         s.name_len = $urandom_range(25, NAME_MAX_LEN - 1);
      else
         s.name_len = NAME_MAX_LEN;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         s.qtype = QTYPE_A;
      else if (pick < 90)
         s.qtype = QTYPE_AAAA;
      else
         s.qtype = 16'($urandom_range(0, 65535));
      s.qclass  = chance(92) ? QCLASS_IN : 16'($urandom_range(0, 65535));
      s.trail   = $urandom_range(0, 10);
      s.results = ANY;
      if (s.fill == FILL_NOISE)
         s.cut = $urandom_range(1, 120);
      else if (chance(8))
         s.cut = $urandom_range(1, NAME_START + s.name_len + s.trail + 5);
      else
         s.cut = NO_CUT;
      return s;
   endfunction

   // Directed frames, all sent with the port register at its reset value. A
   // typed count is given only where it follows directly from the frame: the
   // name length decides the slice count, and any failed check gives none.
   frame_spec_t directed_rows [24] = '{
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h01, 12, QTYPE_A, QCLASS_IN, 3, NO_CUT, ANY},
   '{FILL_ZERO, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 0, QTYPE_AAAA, QCLASS_IN, 2, NO_CUT, 1},
   '{FILL_ONES, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h07, 7, QTYPE_A, QCLASS_IN, 2, NO_CUT, 1},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 8, QTYPE_AAAA, QCLASS_IN, 0, NO_CUT, 2},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 255, QTYPE_A, QCLASS_IN, 4, NO_CUT, 32},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 256, QTYPE_A, QCLASS_IN, 4, NO_CUT, 0},
   '{FILL_RAND, 16'h86DD, PROTO_UDP, DNS_PORT, 8'h00, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, 16'h0801, PROTO_UDP, DNS_PORT, 8'h00, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, 8'd6, DNS_PORT, 8'h00, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, 16'd54, 8'h00, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h80, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h08, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_ONES, ETH_IP4, PROTO_UDP, DNS_PORT, 8'hFF, 6, QTYPE_A, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 6, 16'd2, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 6, 16'hFFFF, QCLASS_IN, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 6, QTYPE_A, 16'd3, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 6, QTYPE_AAAA, 16'hFFFF, 1, NO_CUT, 0},
   '{FILL_ZERO, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 6, QTYPE_A, 16'h0000, 1, NO_CUT, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 5, QTYPE_A, QCLASS_IN, 0, 63, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 5, QTYPE_A, QCLASS_IN, 0, 1, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 5, QTYPE_A, QCLASS_IN, 0, 13, 0},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h02, 20, QTYPE_AAAA, QCLASS_IN, 0, NO_CUT, ANY},
   '{FILL_RAND, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 10, QTYPE_A, QCLASS_IN, 1000, NO_CUT, ANY},
   '{FILL_ONES, ETH_IP4, PROTO_UDP, DNS_PORT, 8'h00, 15, QTYPE_A, QCLASS_IN, 5, NO_CUT, ANY}
   };

   // ------------------------------------------------------------------------
   // Input side. Items are driven at the rising edge. After an acceptance the
   // next item follows in the same time step, so valid is assigned only once
   // per step. The predictor advances at the edge where the handshake
   // completes.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last,
                            inout int results, inout int parsed_count);
      int gap;
      bit parsed;
      gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
      results += predict_byte(b, last, parsed);
      if (parsed)
         parsed_count++;
   endtask

   task automatic send_frame(input frame_spec_t s, output int results,
                             output int parsed_count);
      results      = 0;
      parsed_count = 0;
      build_frame(s);
      // About one frame in five goes through with no gaps between its bytes.
      req_calm = ($urandom_range(0, 4) == 0);
      foreach (frame_bytes[k])
         send_byte(frame_bytes[k], k == frame_bytes.size() - 1, results, parsed_count);
   endtask

   // The block is idle once every predicted result has been taken and the last
   // frame has had time to leave the parser.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_slices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_port(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      port_setting  = value;
   endtask

   // ------------------------------------------------------------------------
   // Result side. Every accepted item is compared field by field with the
   // oldest expectation. After each item a fresh random stall, bounded by MAX_GAP,
   // is drawn. Stretches without stalls come and go at random.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_slice(input rsp_type got);
      rsp_type want;
      if (expected_slices.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         error_count++;
         return;
      end
      want = expected_slices.pop_front();
      check_field("src_addr", want.src_addr, got.src_addr);
      check_field("dst_addr", want.dst_addr, got.dst_addr);
      check_field("src_port", want.src_port, got.src_port);
      check_field("dst_port", want.dst_port, got.dst_port);
      check_field("query_id", want.query_id, got.query_id);
      check_field("query_type", want.query_type, got.query_type);
      check_field("query_class", want.query_class, got.query_class);
      check_field("name_length", want.name_length, got.name_length);
      check_field("chunk_index", want.chunk_index, got.chunk_index);
      check_field("name_chunk", want.name_chunk, got.name_chunk);
      check_field("last_chunk", want.last_chunk, got.last_chunk);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_slice(rsp_item);
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // The watchdog counts cycles in which neither channel moves an item. When the
   // count reaches WATCHDOG_LIMIT, the run stops as failed.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Run order. First reset and the directed frames at the reset port value.
   // Then phases of random frames, one for each port setting, with the
   // extremes among them. Each register write waits until the block is idle.
   // ------------------------------------------------------------------------
   initial begin
      frame_spec_t s;
      int          results;
      int          parsed;
      int          phase_results;
      int          phase_bytes;
      logic [15:0] phase_ports [4];

      port_setting = WATCHED_PORT_RESET;
      clear_frame_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_frame(directed_rows[r], results, parsed);
         if (directed_rows[r].results != ANY && results != directed_rows[r].results) begin
            $display("%0t: directed frame %0d, expected %0d results, actual %0d",
                     $time, r, directed_rows[r].results, results);
            error_count++;
         end
      end

      phase_ports = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)), DNS_PORT};
      foreach (phase_ports[ph]) begin
         settle_block();
         write_port(phase_ports[ph]);
         phase_results = 0;
         phase_bytes   = 0;
         while (phase_bytes < PHASE_BYTES || phase_results < PHASE_RESULTS) begin
            s = random_spec();
            send_frame(s, results, parsed);
            phase_results += results;
            phase_bytes   += parsed;
         end
      end

      // Wait for the last results, then give the block time to show any
      // result that should not come.
      settle_block();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dqpe_pkg.sv
rtl/core/dqpe_ram.sv
rtl/core/dqpe_front.sv
rtl/core/dqpe_queue.sv
rtl/core/dqpe_back.sv
rtl/core/dns_query_packet_extractor.sv
tb/sv/dns_query_packet_extractor_test.sv
